FILE: sv/sequenced_history_ring_macros.svh
// ----------------------------------------------------------------------------
// sequenced_history_ring_macros
// Assertion macros shared by the history ring RTL.
// ----------------------------------------------------------------------------
`ifndef SEQUENCED_HISTORY_RING_MACROS_SVH
`define SEQUENCED_HISTORY_RING_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SHR_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SHR_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/shr_pkg.sv
// ----------------------------------------------------------------------------
// shr_pkg
// Types, constants and helpers for the sequenced history ring.
// ----------------------------------------------------------------------------
package shr_pkg;

    localparam int DEPTH         = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam int SLOT_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int SEQ_W         = 64;
    localparam int PAYLOAD_W     = 64;
    localparam int LEN_W         = 4;
    localparam int ENTRY_W       = PAYLOAD_W + LEN_W + 1;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 264;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NONE   = 2'd1,
        STATUS_REJECT = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_OLDEST,
        ST_COMPARE,
        ST_LOOKUP,
        ST_RESP
    } state_t;

    // slot = sum mod cap, valid for sum < 2*cap
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] sum,
                                                    input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] r;
        r = (sum >= {1'b0, cap}) ? sum - {1'b0, cap} : sum;
        return r[SLOT_W-1:0];
    endfunction

endpackage

FILE: sv/sequenced_history_ring.sv
// ----------------------------------------------------------------------------
// sequenced_history_ring
// History ring with sequence numbered entries and reader cursor catch-up.
// ----------------------------------------------------------------------------
// Input stream s_axis: one word per operation. tuser selects push or read.
// Output stream m_axis: exactly one result word per input word, in order;
// tuser carries the status code.
// Config channel cfg_*: writes the ring capacity (0 acts as 1, above DEPTH
// acts as DEPTH) and empties the ring; sequence numbering continues.
// Write it only while no operation is in flight.
// Flow: one operation at a time, set by the FSM sequencing around the
// entry memory. A push passes through the push state into the output
// register; a read passes through oldest sequence, cursor compare, a
// registered memory read and result load. Each operation ends back in
// idle, where the next word is accepted.
// The result sits in an output register; the next word is accepted while it
// waits. If the receiver stalls, the following operation holds in its last
// state until the output register frees.
// Reset: ring empty, capacity DEPTH, next sequence number 1. Entry memory
// is not cleared; only entries written since the last emptying are read.
// ----------------------------------------------------------------------------
`include "sequenced_history_ring_macros.svh"

module sequenced_history_ring
    import shr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // cfg_data: ring_capacity[4:0]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: push_payload[63:0], push_length[67:64], push_is_text[68],
    //        read_cursor[132:69], zero pad[135:133]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: op[0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: read_payload[63:0], read_length[67:64], read_is_text[68],
    //        new_cursor[132:69], missed_count[196:133],
    //        upcoming_sequence[260:197], zero pad[263:261]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0]
    output logic [1:0]            m_axis_tuser
);

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cap_reg, cap_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [SLOT_W-1:0]      oldest_slot_reg, oldest_slot_next;
    logic [SEQ_W-1:0]       next_seq_reg, next_seq_next;
    logic                   m_valid_reg, m_valid_next;

    op_t                    op_reg;
    logic [PAYLOAD_W-1:0]   in_payload_reg;
    logic [LEN_W-1:0]       in_len_reg;
    logic                   in_text_reg;
    logic [SEQ_W-1:0]       in_cursor_reg;

    logic [SEQ_W-1:0]       oldest_seq_reg, oldest_seq_next;
    logic [SEQ_W-1:0]       cursor_reg, cursor_next;
    logic [SEQ_W-1:0]       missed_reg, missed_next;
    logic [SEQ_W-1:0]       diff_reg, diff_next;
    logic                   ge_next_reg, ge_next_next;
    logic [SEQ_W-1:0]       cur_plus_reg, cur_plus_next;
    logic                   none_reg, none_next;

    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    logic [ENTRY_W-1:0]     mem [DEPTH];
    logic [ENTRY_W-1:0]     mem_q_reg;
    logic                   mem_we;
    logic [SLOT_W-1:0]      mem_waddr;
    logic [ENTRY_W-1:0]     mem_wdata;
    logic                   mem_re;
    logic [SLOT_W-1:0]      mem_raddr;

    logic                   in_accept;
    logic                   cfg_write;
    logic                   out_free;
    logic                   out_load;
    logic                   push_reject;
    logic [PAYLOAD_W-1:0]   masked_payload;
    logic [SEQ_W:0]         cursor_diff;
    logic                   cursor_lt;
    logic [SEQ_W-1:0]       cursor_eff;
    logic                   diff_small;

    assign cfg_ready     = 1'b1;
    assign cfg_write     = cfg_valid & cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

    assign push_reject = (in_len_reg == '0) || (in_len_reg > LEN_W'(PAYLOAD_BYTES));
    assign cursor_diff = {1'b0, in_cursor_reg} - {1'b0, oldest_seq_reg};
    assign cursor_lt   = cursor_diff[SEQ_W];
    assign cursor_eff  = cursor_lt ? oldest_seq_reg : in_cursor_reg;
    assign diff_small  = (diff_reg[SEQ_W-1:CNT_W] == '0);

    always_comb
    begin
        for (int b = 0; b < PAYLOAD_W / 8; b++)
        begin
            masked_payload[b*8 +: 8] = (LEN_W'(b) < in_len_reg) ? in_payload_reg[b*8 +: 8]
                                                                 : 8'd0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        cap_next         = cap_reg;
        count_next       = count_reg;
        oldest_slot_next = oldest_slot_reg;
        next_seq_next    = next_seq_reg;
        oldest_seq_next  = oldest_seq_reg;
        cursor_next      = cursor_reg;
        missed_next      = missed_reg;
        diff_next        = diff_reg;
        ge_next_next     = ge_next_reg;
        cur_plus_next    = cur_plus_reg;
        none_next        = none_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        out_load         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = oldest_slot_reg;
        mem_wdata        = {in_text_reg, in_len_reg, masked_payload};
        mem_re           = 1'b0;
        mem_raddr        = wrap_slot((CNT_W + 1)'(oldest_slot_reg) +
                                     (CNT_W + 1)'(diff_reg[SLOT_W-1:0]), cap_reg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (op_t'(s_axis_tuser[0]) == OP_PUSH) ? ST_PUSH : ST_OLDEST;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (push_reject)
                    begin
                        m_tuser_next = STATUS_REJECT;
                        m_tdata_next = {3'd0, next_seq_reg, {(OUT_DATA_W - 3 - SEQ_W){1'b0}}};
                    end
                    else
                    begin
                        mem_we        = 1'b1;
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                        if (count_reg == cap_reg)
                        begin
                            mem_waddr        = oldest_slot_reg;
                            oldest_slot_next = ((CNT_W)'(oldest_slot_reg) + CNT_W'(1) == cap_reg)
                                               ? '0 : oldest_slot_reg + SLOT_W'(1);
                        end
                        else
                        begin
                            mem_waddr  = wrap_slot((CNT_W + 1)'(oldest_slot_reg) +
                                                   (CNT_W + 1)'(count_reg), cap_reg);
                            count_next = count_reg + CNT_W'(1);
                        end
                        m_tuser_next = STATUS_OK;
                        m_tdata_next = {3'd0, next_seq_next,
                                        {(OUT_DATA_W - 3 - SEQ_W){1'b0}}};
                    end
                end
            end
            ST_OLDEST:
            begin
                oldest_seq_next = next_seq_reg - SEQ_W'(count_reg);
                state_next      = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                missed_next  = cursor_lt ? oldest_seq_reg - in_cursor_reg : '0;
                cursor_next  = cursor_eff;
                diff_next    = cursor_lt ? '0 : cursor_diff[SEQ_W-1:0];
                ge_next_next = (cursor_eff >= next_seq_reg);
                state_next   = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                none_next     = ge_next_reg || !(diff_small && (diff_reg[CNT_W-1:0] < count_reg));
                cur_plus_next = cursor_reg + SEQ_W'(1);
                mem_re        = 1'b1;
                state_next    = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                    if (none_reg)
                    begin
                        m_tuser_next = STATUS_NONE;
                        m_tdata_next = {3'd0, next_seq_reg, missed_reg, cursor_reg,
                                        {ENTRY_W{1'b0}}};
                    end
                    else
                    begin
                        m_tuser_next = STATUS_OK;
                        m_tdata_next = {3'd0, next_seq_reg, missed_reg, cur_plus_reg,
                                        mem_q_reg};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            if (cfg_data == '0)
            begin
                cap_next = CNT_W'(1);
            end
            else if (cfg_data > CNT_W'(DEPTH))
            begin
                cap_next = CNT_W'(DEPTH);
            end
            else
            begin
                cap_next = cfg_data;
            end
            count_next       = '0;
            oldest_slot_next = '0;
        end
    end

    assign m_valid_next = out_load | (m_valid_reg & ~m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cap_reg         <= CNT_W'(DEPTH);
            count_reg       <= '0;
            oldest_slot_reg <= '0;
            next_seq_reg    <= SEQ_W'(1);
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cap_reg         <= cap_next;
            count_reg       <= count_next;
            oldest_slot_reg <= oldest_slot_next;
            next_seq_reg    <= next_seq_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg         <= op_t'(s_axis_tuser[0]);
            in_payload_reg <= s_axis_tdata[PAYLOAD_W-1:0];
            in_len_reg     <= s_axis_tdata[PAYLOAD_W +: LEN_W];
            in_text_reg    <= s_axis_tdata[PAYLOAD_W + LEN_W];
            in_cursor_reg  <= s_axis_tdata[ENTRY_W +: SEQ_W];
        end
        oldest_seq_reg <= oldest_seq_next;
        cursor_reg     <= cursor_next;
        missed_reg     <= missed_next;
        diff_reg       <= diff_next;
        ge_next_reg    <= ge_next_next;
        cur_plus_reg   <= cur_plus_next;
        none_reg       <= none_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // entry memory: {text, length, payload}
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            mem_q_reg <= mem[mem_raddr];
        end
    end

    `SHR_CHECK(a_count_within_cap, 1'b1, count_reg <= cap_reg,
               "stored count exceeds capacity")
    `SHR_CHECK(a_oldest_within_cap, 1'b1, oldest_slot_reg < cap_reg,
               "oldest slot outside capacity")
    `SHR_CHECK_NEXT(a_push_advances_seq,
                    (state_reg == ST_PUSH) && out_free && !push_reject,
                    next_seq_reg == $past(next_seq_reg) + SEQ_W'(1),
                    "accepted push did not advance sequence")
    `SHR_CHECK(a_read_uses_read_path,
               (state_reg == ST_OLDEST) || (state_reg == ST_RESP),
               op_reg == OP_READ,
               "read sequence entered for a push")

endmodule

FILE: tb/sv/shr_checker.sv
// ----------------------------------------------------------------------------
// shr_checker
// Watches the config, input and result streams of the sequenced history ring,
// keeps its own copy of the ring, predicts one result word per accepted input
// word and compares every accepted result word field by field, in order.
// ----------------------------------------------------------------------------
module shr_checker
    import shr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic [1:0]            m_axis_tuser,
    output int                    errors,
    output int                    in_flight,
    output logic [SEQ_W-1:0]      upcoming_seq
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]           status;
        logic [PAYLOAD_W-1:0] payload;
        logic [LEN_W-1:0]     length;
        logic                 text;
        logic [SEQ_W-1:0]     cursor;
        logic [SEQ_W-1:0]     missed;
        logic [SEQ_W-1:0]     upcoming;
    } ring_result_t;

    logic [PAYLOAD_W-1:0] pay_mem [DEPTH];
    logic [LEN_W-1:0]     len_mem [DEPTH];
    logic                 txt_mem [DEPTH];
    logic [SEQ_W-1:0]     seq_mem [DEPTH];
    int                   head;
    int                   held;
    logic [SEQ_W-1:0]     nseq;
    logic [CNT_W-1:0]     cap_raw;
    int                   err_cnt = 0;
    ring_result_t         awaited_results [$];

    task automatic predict_ring_op(input op_t op, input logic [IN_DATA_W-1:0] d,
                                   output ring_result_t r);
        logic [PAYLOAD_W-1:0] mask;
        logic [SEQ_W-1:0]     oldest;
        logic [SEQ_W-1:0]     cur;
        logic [LEN_W-1:0]     len;
        int                   cap;
        int                   slot;
        cap = (cap_raw == 0) ? 1 : ((int'(cap_raw) > DEPTH) ? DEPTH : int'(cap_raw));
        if (head >= cap)
            head = 0;
        if (held > cap)
            held = cap;
        r.status   = STATUS_OK;
        r.payload  = '0;
        r.length   = '0;
        r.text     = 1'b0;
        r.cursor   = '0;
        r.missed   = '0;
        len        = d[67:64];
        if (op == OP_PUSH)
        begin
            if (len == 0 || int'(len) > PAYLOAD_BYTES)
                r.status = STATUS_REJECT;
            else
            begin
                if (held == cap)
                begin
                    slot = head;
                    head = (head + 1) % cap;
                end
                else
                begin
                    slot = (head + held) % cap;
                    held++;
                end
                mask = (len >= 8) ? '1 : ((64'd1 << (8 * int'(len))) - 64'd1);
                pay_mem[slot] = d[63:0] & mask;
                len_mem[slot] = len;
                txt_mem[slot] = d[68];
                seq_mem[slot] = nseq;
                nseq = nseq + 1;
            end
        end
        else
        begin
            oldest = (held != 0) ? seq_mem[head] : nseq;
            cur = d[132:69];
            if (cur < oldest)
            begin
                r.missed = oldest - cur;
                cur = oldest;
            end
            if (cur >= nseq || (cur - oldest) >= held)
                r.status = STATUS_NONE;
            else
            begin
                slot = (head + int'(cur - oldest)) % cap;
                r.payload = pay_mem[slot];
                r.length  = len_mem[slot];
                r.text    = txt_mem[slot];
                cur = seq_mem[slot] + 1;
            end
            r.cursor = cur;
        end
        r.upcoming = nseq;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ring_result_t want_r;
        ring_result_t got_r;
        ring_result_t new_r;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pay_mem[i] = '0;
                len_mem[i] = '0;
                txt_mem[i] = 1'b0;
                seq_mem[i] = '0;
            end
            head    = 0;
            held    = 0;
            nseq    = 1;
            cap_raw = CNT_W'(DEPTH);
            awaited_results.delete();
            in_flight    <= 0;
            upcoming_seq <= 1;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_r.status   = m_axis_tuser;
                got_r.payload  = m_axis_tdata[63:0];
                got_r.length   = m_axis_tdata[67:64];
                got_r.text     = m_axis_tdata[68];
                got_r.cursor   = m_axis_tdata[132:69];
                got_r.missed   = m_axis_tdata[196:133];
                got_r.upcoming = m_axis_tdata[260:197];
                if (awaited_results.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t ns: unexpected result word, expected none, actual %h",
                             $time, got_r);
                end
                else
                begin
                    want_r = awaited_results.pop_front();
                    check_field("status", 64'(want_r.status), 64'(got_r.status));
                    check_field("read_payload", want_r.payload, got_r.payload);
                    check_field("read_length", 64'(want_r.length), 64'(got_r.length));
                    check_field("read_is_text", 64'(want_r.text), 64'(got_r.text));
                    check_field("new_cursor", want_r.cursor, got_r.cursor);
                    check_field("missed_count", want_r.missed, got_r.missed);
                    check_field("upcoming_sequence", want_r.upcoming, got_r.upcoming);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                cap_raw = cfg_data;
                head    = 0;
                held    = 0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_ring_op(op_t'(s_axis_tuser), s_axis_tdata, new_r);
                awaited_results.push_back(new_r);
            end
            in_flight    <= awaited_results.size();
            upcoming_seq <= nseq;
        end
        errors <= err_cnt;
    end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the sequenced history ring: clock, reset, a directed
// opening, then random pushes and reads over several ring capacities with
// random idle bursts on both streams (none in the last phase); the checker module does the scoring.
// ----------------------------------------------------------------------------
module tb;
    import shr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CNT_W-1:0]      cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    int                    errors;
    int                    in_flight;
    logic [SEQ_W-1:0]      upcoming_seq;
    bit                    quiet = 1'b0;

    sequenced_history_ring u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    shr_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .in_flight     (in_flight),
        .upcoming_seq  (upcoming_seq)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_word(input op_t op, input logic [63:0] payload,
                             input logic [3:0] len, input logic text,
                             input logic [63:0] cursor);
        s_axis_tdata  <= {3'b000, cursor, text, len, payload};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic random_word();
        logic [63:0] payload;
        logic [63:0] cursor;
        logic [3:0]  len;
        int          pick;
        payload = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 55)
        begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            else
                len = 4'($urandom_range(1, PAYLOAD_BYTES));
            send_word(OP_PUSH, payload, len, 1'($urandom), {$urandom, $urandom});
        end
        else
        begin
            pick = $urandom_range(0, 11);
            if (pick == 0)
                cursor = {$urandom, $urandom};
            else if (pick == 1)
                cursor = '0;
            else
                cursor = upcoming_seq - 64'($urandom_range(0, 20));
            send_word(OP_READ, payload, 4'($urandom), 1'($urandom), cursor);
        end
    endtask

    // wait for the ring to drain, then let the last operation settle
    task automatic drain();
        if (s_axis_tvalid)
            s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] value);
        drain();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int caps [7] = '{1, 0, 31, 17, 2, 16, 5};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty ring reads, rejects, byte masking, text flag, catch-up
        send_word(OP_READ, '0, '0, 1'b0, 64'd0);
        send_word(OP_READ, '0, '0, 1'b0, 64'd1);
        send_word(OP_PUSH, '1, 4'd0, 1'b1, '0);
        send_word(OP_PUSH, '1, 4'd9, 1'b1, '0);
        send_word(OP_PUSH, '1, 4'd15, 1'b0, '1);
        send_word(OP_PUSH, '1, 4'd1, 1'b0, '0);
        send_word(OP_PUSH, '1, 4'd8, 1'b1, '1);
        send_word(OP_PUSH, '0, 4'd4, 1'b1, '0);
        send_word(OP_PUSH, 64'h0123_4567_89ab_cdef, 4'd5, 1'b0, '0);
        send_word(OP_READ, '1, '1, 1'b1, 64'd0);
        send_word(OP_READ, '0, '0, 1'b0, 64'd1);
        send_word(OP_READ, '0, '0, 1'b0, 64'd4);
        send_word(OP_READ, '0, '0, 1'b0, 64'd5);
        send_word(OP_READ, '0, '0, 1'b0, '1);
        send_word(OP_READ, '0, '0, 1'b0, 64'd3);

        for (int phase = 0; phase < 8; phase++)
        begin
            write_capacity((phase < 7) ? CNT_W'(caps[phase]) : CNT_W'($urandom_range(0, 31)));
            if (phase == 7)
                quiet = 1'b1;
            repeat (135) random_word();
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
